@@ sv/ste_pkg.sv @@
// Package for the symbol token expander: sizes, codes and the identifier check.
// No dependencies; imported by the top level.
package ste_pkg;

  localparam int TABLE_BYTES       = 16384;
  localparam int MAX_SYMBOL_TOKENS = 256;
  localparam int MAX_TOKEN_CHARS   = 63;
  localparam int OFFSET_ENTRIES    = 256;

  // field widths fixed by the interface
  localparam int KIND_W  = 2;
  localparam int LOC_W   = 14;
  localparam int VALUE_W = 14;
  localparam int CFG_W   = 15;
  localparam int BYTE_W  = 8;

  // derived sizes
  localparam int ADDR_W = $clog2(TABLE_BYTES);
  localparam int OFF_AW = $clog2(OFFSET_ENTRIES);
  // walk position: holds any start offset or table address plus one step past it
  localparam int POS_W  = ((ADDR_W > VALUE_W) ? ADDR_W : VALUE_W) + 1;
  localparam int CNT_W  = $clog2(MAX_TOKEN_CHARS + 1);
  localparam int TOK_W  = $clog2(MAX_SYMBOL_TOKENS + 1);

  // input item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TABLE  = 2'd0,
    KIND_OFFSET = 2'd1,
    KIND_STREAM = 2'd2
  } in_kind_t;

  // result kinds
  typedef enum logic [1:0] {
    RES_CHAR = 2'd0,
    RES_OK   = 2'd1,
    RES_BAD  = 2'd2
  } res_kind_t;

  localparam logic [BYTE_W-1:0] LEN_EXT_BIT = 8'h80;
  localparam logic [6:0]        LEN_LOW_MASK = 7'h7f;

  // a-z, A-Z, 0-9, underscore, dot, dollar
  function automatic logic is_ident(input logic [BYTE_W-1:0] c);
    is_ident = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "_" || c == "." || c == "$";
  endfunction

endpackage

@@ sv/symbol_token_expander.sv @@
// Symbol token expander: expands length-prefixed token strings against two RAMs;
// depends on ste_pkg and ste_ram. One item at a time: a bad length goes to the
// finishing transaction; a token does an offset lookup, a fetch and a char step
// per table byte, an extra fetch at the char cap or table end, then token end,
// flush and, after the last token, finishing; output back-pressure adds stalls.
// Reset clears the decoder and sets limit to the full table; RAMs start undefined.
module symbol_token_expander
  import ste_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  kind,
  input  logic [LOC_W-1:0]   location,
  input  logic [VALUE_W-1:0] value,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         result_kind,
  output logic [BYTE_W-1:0]  character,
  output logic [BYTE_W-1:0]  type_char,
  output logic               last
);

  typedef enum logic [2:0] {
    S_IDLE, S_OFFS, S_FETCH, S_CHAR, S_TEND, S_FLUSH, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_LEN0, PH_LEN1, PH_TOK
  } phase_t;

  state_t             state;
  phase_t             phase;
  logic [6:0]         length_low_bits;
  logic [TOK_W-1:0]   tokens_remaining;
  logic               have_type;
  logic [BYTE_W-1:0]  held_type;
  logic               name_nonempty;
  logic               name_bad;
  logic [POS_W-1:0]   limit;
  logic [POS_W-1:0]   pos;
  logic [CNT_W-1:0]   count;
  logic               pend_valid;
  logic [BYTE_W-1:0]  pend_char;
  logic               fin_go;

  logic               in_fire;
  logic               slot_free;
  logic               out_load;
  logic [BYTE_W-1:0]  in_byte;
  logic [CFG_W-1:0]   len_word;
  logic               len_bad;
  logic               walk_on;
  logic [TOK_W-1:0]   tokens_left;

  logic               byte_we;
  logic               byte_re;
  logic [BYTE_W-1:0]  byte_rdata;
  logic               off_we;
  logic               off_re;
  logic [VALUE_W-1:0] off_rdata;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign in_byte   = value[BYTE_W-1:0];

  // output register loads this cycle
  always_comb begin
    unique case (state)
      S_CHAR:  out_load = (byte_rdata != '0) && have_type && pend_valid && slot_free;
      S_FLUSH: out_load = pend_valid && slot_free;
      S_FIN:   out_load = slot_free;
      default: out_load = 1'b0;
    endcase
  end

  // length as completed by this byte (one- or two-byte form)
  always_comb begin
    if (phase == PH_LEN1) begin
      len_word = {in_byte, length_low_bits};
    end else begin
      len_word = CFG_W'(in_byte);
    end
  end
  assign len_bad = (len_word == '0) || (32'(len_word) > MAX_SYMBOL_TOKENS);

  // walk continues while under the char cap and inside the table
  assign walk_on     = (32'(count) < MAX_TOKEN_CHARS) && (pos < limit);
  assign tokens_left = tokens_remaining - TOK_W'(1);

  // RAM controls
  assign byte_we = in_fire && (kind == KIND_TABLE) && (32'(location) < TABLE_BYTES);
  assign off_we  = in_fire && (kind == KIND_OFFSET) && (32'(location) < OFFSET_ENTRIES);
  assign off_re  = in_fire && (kind == KIND_STREAM) && (phase == PH_TOK);
  assign byte_re = (state == S_FETCH) && walk_on;

  ste_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_BYTES)
  ) u_bytes (
    .clk   (clk),
    .we    (byte_we),
    .waddr (ADDR_W'(location)),
    .wdata (in_byte),
    .re    (byte_re),
    .raddr (pos[ADDR_W-1:0]),
    .rdata (byte_rdata)
  );

  ste_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (OFFSET_ENTRIES)
  ) u_offsets (
    .clk   (clk),
    .we    (off_we),
    .waddr (location[OFF_AW-1:0]),
    .wdata (value),
    .re    (off_re),
    .raddr (in_byte[OFF_AW-1:0]),
    .rdata (off_rdata)
  );

  // table end register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= POS_W'(TABLE_BYTES);
    end else if (cfg_we) begin
      if (32'(cfg_data) > TABLE_BYTES) begin
        limit <= POS_W'(TABLE_BYTES);
      end else begin
        limit <= POS_W'(cfg_data);
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      phase            <= PH_LEN0;
      length_low_bits  <= '0;
      tokens_remaining <= '0;
      have_type        <= 1'b0;
      held_type        <= '0;
      name_nonempty    <= 1'b0;
      name_bad         <= 1'b0;
      pend_valid       <= 1'b0;
      fin_go           <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (out_ready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire && kind == KIND_STREAM) begin
            unique case (phase)
              PH_TOK: begin
                state <= S_OFFS;
              end
              PH_LEN0, PH_LEN1: begin
                if (phase == PH_LEN0 && (in_byte & LEN_EXT_BIT) != '0) begin
                  length_low_bits <= in_byte[6:0] & LEN_LOW_MASK;
                  phase           <= PH_LEN1;
                end else if (len_bad) begin
                  // malformed length: report at once
                  state <= S_FIN;
                end else begin
                  tokens_remaining <= TOK_W'(len_word);
                  phase            <= PH_TOK;
                end
              end
              default: begin
                phase <= PH_LEN0;
              end
            endcase
          end
        end

        S_OFFS: begin
          pos   <= POS_W'(off_rdata);
          count <= '0;
          state <= S_FETCH;
        end

        S_FETCH: begin
          if (walk_on) begin
            state <= S_CHAR;
          end else begin
            state <= S_TEND;
          end
        end

        S_CHAR: begin
          if (byte_rdata == '0) begin
            state <= S_TEND;
          end else if (!have_type) begin
            have_type <= 1'b1;
            held_type <= byte_rdata;
            pos       <= pos + POS_W'(1);
            count     <= count + CNT_W'(1);
            state     <= S_FETCH;
          end else if (!pend_valid || slot_free) begin
            // older pending char cannot be the last of this transaction
            if (pend_valid) begin
              out_valid   <= 1'b1;
              result_kind <= RES_CHAR;
              character   <= pend_char;
              type_char   <= '0;
              last        <= 1'b0;
            end
            pend_valid    <= 1'b1;
            pend_char     <= byte_rdata;
            name_nonempty <= 1'b1;
            if (!is_ident(byte_rdata)) begin
              name_bad <= 1'b1;
            end
            pos   <= pos + POS_W'(1);
            count <= count + CNT_W'(1);
            state <= S_FETCH;
          end
        end

        S_TEND: begin
          tokens_remaining <= tokens_left;
          fin_go           <= (tokens_left == '0);
          state            <= S_FLUSH;
        end

        S_FLUSH: begin
          if (!pend_valid) begin
            state <= fin_go ? S_FIN : S_IDLE;
          end else if (slot_free) begin
            out_valid   <= 1'b1;
            result_kind <= RES_CHAR;
            character   <= pend_char;
            type_char   <= '0;
            last        <= !fin_go;
            pend_valid  <= 1'b0;
            state       <= fin_go ? S_FIN : S_IDLE;
          end
        end

        S_FIN: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            result_kind <= (have_type && name_nonempty && !name_bad) ? RES_OK : RES_BAD;
            character   <= '0;
            type_char   <= have_type ? held_type : '0;
            last        <= 1'b1;
            // start the next symbol
            phase            <= PH_LEN0;
            length_low_bits  <= '0;
            tokens_remaining <= '0;
            have_type        <= 1'b0;
            held_type        <= '0;
            name_nonempty    <= 1'b0;
            name_bad         <= 1'b0;
            fin_go           <= 1'b0;
            state            <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/ste_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds until the next read. No dependencies.
module ste_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
